FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising edge, off while reset is asserted
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every rising edge, reset included
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Types, sizes and helpers for the sliding window maximum block
// ----------------------------------------------------------------------------
package swm_pkg;

    // deepest window and sample width
    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;

    // window size register width
    localparam int CFG_W = 7;

    // cell index and sample count widths
    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int K_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef t_sample [WINDOW_MAX-1:0]       t_sample_row;
    typedef logic [CFG_W-1:0]               t_cfg;
    typedef logic [CNT_W-1:0]               t_count;
    typedef logic [IDX_W-1:0]               t_index;

    // control word broadcast to every cell of the chain
    typedef struct packed {
        logic    shift;
        logic    restart;
        t_sample sample;
    } t_cell_ctl;

    // window size as used: zero reads as one, large values clip to the depth
    function automatic t_count eff_size(input t_cfg ws);
        logic [K_W-1:0] w;
        w = K_W'(ws);
        if (w == '0) begin
            return CNT_W'(1);
        end
        if (w > K_W'(WINDOW_MAX)) begin
            return CNT_W'(WINDOW_MAX);
        end
        return CNT_W'(w);
    endfunction

endpackage

FILE: rtl/swm_in_if.sv
// ----------------------------------------------------------------------------
// swm_in_if
// Sample channel: valid/ready handshake with sample and restart flag
// ----------------------------------------------------------------------------
interface swm_in_if;
    logic             valid;
    logic             ready;
    swm_pkg::t_sample sample;
    logic             restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

FILE: rtl/swm_out_if.sv
// ----------------------------------------------------------------------------
// swm_out_if
// Result channel: valid/ready handshake with the window maximum
// ----------------------------------------------------------------------------
interface swm_out_if;
    logic             valid;
    logic             ready;
    swm_pkg::t_sample window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

FILE: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One chain cell: holds the max of the last (position + 1) samples
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic               i_clk,
    input  swm_pkg::t_cell_ctl i_ctl,
    input  swm_pkg::t_sample   i_prev,
    output swm_pkg::t_sample   o_value,
    output swm_pkg::t_sample   o_next
);

    swm_pkg::t_sample r_value;

    // new max: the sample against the left neighbor's window, or the sample alone on restart
    always_comb begin
        if (i_ctl.restart) begin
            o_next = i_ctl.sample;
        end else if (i_ctl.sample > i_prev) begin
            o_next = i_ctl.sample;
        end else begin
            o_next = i_prev;
        end
    end

    // take the new value on each accepted word
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= o_next;
        end
    end

    assign o_value = r_value;

endmodule

FILE: rtl/swm_chain.sv
// ----------------------------------------------------------------------------
// swm_chain
// Row of cells; cell j tracks the max over the last j + 1 samples
// ----------------------------------------------------------------------------
module swm_chain (
    input  logic                 i_clk,
    input  swm_pkg::t_cell_ctl   i_ctl,
    output swm_pkg::t_sample_row o_next
);

    swm_pkg::t_sample_row w_value;

    // cell 0 sees the sample itself, the rest see their left neighbor
    for (genvar g = 0; g < swm_pkg::WINDOW_MAX; g++) begin : g_cell
        if (g == 0) begin : g_head
            swm_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_prev  (i_ctl.sample),
                .o_value (w_value[g]),
                .o_next  (o_next[g])
            );
        end else begin : g_body
            swm_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_prev  (w_value[g-1]),
                .o_value (w_value[g]),
                .o_next  (o_next[g])
            );
        end
    end

endmodule

FILE: rtl/sliding_window_max_top.sv
// ----------------------------------------------------------------------------
// sliding_window_max_top
// Running maximum over the last window_size signed samples
// ----------------------------------------------------------------------------
// One sample word is taken per clock while the output is not stalled. A row
// of 64 cells holds, in cell j, the largest of the last j + 1 samples since
// the last restart; each accepted word shifts one compare-and-select step
// down the row. The result word, from cell window_size-1, enters the output
// register as its sample is taken. No result is given until window_size
// samples have arrived since reset or the last restart. A window size of zero
// acts as one and sizes above 64 act as 64. There is no clearing pass after
// reset. The user must write the window size register only while no word is
// in flight; the block itself does not enforce this.
module sliding_window_max_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  swm_pkg::t_cfg        i_cfg_wdata,
    swm_in_if.sink               i_in,
    swm_out_if.source            o_out
);

`include "assert_macros.svh"

    swm_pkg::t_cfg        r_win_size;
    swm_pkg::t_count      r_seen;
    logic                 r_live;
    logic                 r_out_valid;
    swm_pkg::t_sample     r_out_word;

    swm_pkg::t_count      n_seen;
    swm_pkg::t_count      w_k;
    swm_pkg::t_count      w_seen_base;
    swm_pkg::t_index      w_sel;
    logic                 w_in_acc;
    logic                 w_restart;
    logic                 w_emit;
    swm_pkg::t_cell_ctl   w_ctl;
    swm_pkg::t_sample_row w_next;

    // handshake: output register frees as the result word leaves
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_acc   = i_in.valid && i_in.ready;

    // first word after reset starts a fresh window
    assign w_restart = i_in.restart || !r_live;
    assign w_k       = swm_pkg::eff_size(r_win_size);
    assign w_sel     = swm_pkg::IDX_W'(w_k - swm_pkg::CNT_W'(1));

    // cell row control
    assign w_ctl.shift   = w_in_acc;
    assign w_ctl.restart = w_restart;
    assign w_ctl.sample  = i_in.sample;

    swm_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_next (w_next)
    );

    // samples since restart, clipped to the window and saturating there
    always_comb begin
        w_seen_base = w_restart ? '0 : r_seen;
        if (w_seen_base > w_k) begin
            w_seen_base = w_k;
        end
        if (w_seen_base < w_k) begin
            n_seen = w_seen_base + swm_pkg::CNT_W'(1);
        end else begin
            n_seen = w_seen_base;
        end
        w_emit = (n_seen >= w_k);
    end

    // control state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size  <= swm_pkg::CFG_W'(1);
            r_seen      <= '0;
            r_live      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win_size <= i_cfg_wdata;
            end
            if (w_in_acc) begin
                r_seen <= n_seen;
                r_live <= 1'b1;
            end
            if (w_in_acc && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word from the cell at the window edge
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_emit) begin
            r_out_word <= w_next[w_sel];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.window_max = r_out_word;

    // checks
    `SWM_ASSERT(a_emit_loads, i_clk, i_rst_n, (w_in_acc && w_emit) |=> r_out_valid, "result word lost")
    `SWM_ASSERT(a_seen_bound, i_clk, i_rst_n, r_seen <= swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX), "sample count past depth")
    `SWM_ASSERT(a_restart_one, i_clk, i_rst_n, (w_in_acc && w_restart) |=> (r_seen == swm_pkg::CNT_W'(1)), "restart count wrong")
    `SWM_ASSERT(a_unit_window, i_clk, i_rst_n, (w_in_acc && (w_k == swm_pkg::CNT_W'(1))) |=> (r_out_word == $past(i_in.sample)), "unit window mismatch")

endmodule
